// ===== rtl/skis_pkg.sv =====
`default_nettype none

package skis_pkg;

    // Field widths
    localparam int KEY_W       = 31;
    localparam int HELD_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 3;
    localparam int DEPTH_DEF   = 8;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W   = ((KEY_W + HELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((STATUS_W + SLOT_W + 7) / 8) * 8;

    // Command codes carried on s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_DUP       = 2'd2,
        ST_NOT_FOUND = 2'd3
    } skis_status_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             ins_en;
        logic             rem_en;
    } skis_cmd_t;

    // What a cell shows its right-hand neighbor
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             gt;   // slot empty or holds a key above the search key
        logic             ge;   // gt, or slot holds the search key
    } skis_link_t;

endpackage

`default_nettype wire

// ===== rtl/skis_cell.sv =====
`default_nettype none

module skis_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  skis_pkg::skis_cmd_t       cmd_i,
    input  skis_pkg::skis_link_t      left_i,
    input  logic [skis_pkg::KEY_W-1:0] right_key_i,
    output skis_pkg::skis_link_t      link_o,
    output logic                      ins_bnd_o,
    output logic                      rem_bnd_o,
    output logic                      eq_o
);
    import skis_pkg::*;

    logic [KEY_W-1:0] slot_reg;
    logic [KEY_W-1:0] slot_next;
    logic             empty;
    logic             gt;
    logic             ge;

    // Compare against the search key
    always_comb begin
        empty = (slot_reg == '0);
        eq_o  = (slot_reg == cmd_i.key);
        gt    = empty || (cmd_i.key < slot_reg);
        ge    = gt || eq_o;
    end

    assign link_o    = '{key: slot_reg, gt: gt, ge: ge};
    // First cell of each thermometer
    assign ins_bnd_o = gt && !left_i.gt;
    assign rem_bnd_o = ge && !left_i.ge;

    // Insert shifts up from the boundary, remove shifts down
    always_comb begin
        slot_next = slot_reg;
        if (cmd_i.ins_en && gt) begin
            slot_next = left_i.gt ? left_i.key : cmd_i.key;
        end else if (cmd_i.rem_en && ge) begin
            slot_next = right_key_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else begin
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_set_insert_remove_core.sv =====
`default_nettype none

// Channel  Dir  Ports                               Content
// s_       in   s_tvalid s_tready s_tdata s_tuser   key, held_count; command
// m_       out  m_tvalid m_tready m_tdata           status, slot
//
// One word per cycle: all cells compare the key in parallel and shift in the
// same cycle the word is accepted; the result sits in one output register.
// The slot row updates at acceptance, so the next word sees the new contents.
// Reset (aresetn low, synchronous) empties every slot and drops m_tvalid.
// s_tready is low only while a result is held and m_tready is low.

module sorted_key_set_insert_remove_core #(
    parameter int DEPTH = skis_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [skis_pkg::S_TDATA_W-1:0]  s_tdata,  // [30:0] key, [38:31] held_count
    input  logic [0:0]                      s_tuser,  // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [skis_pkg::M_TDATA_W-1:0]  m_tdata   // [1:0] status, [4:2] slot
);
    import skis_pkg::*;

    logic [KEY_W-1:0]  cmd_key;
    logic [HELD_W-1:0] held;
    logic              is_rem;
    logic              accept;
    skis_cmd_t         cmd;

    skis_link_t        link_vec [DEPTH];
    logic [DEPTH-1:0]  ins_bnd;
    logic [DEPTH-1:0]  rem_bnd;
    logic [DEPTH-1:0]  eq_vec;

    logic              key_zero;
    logic              any_eq;
    logic              found;
    logic              room;
    skis_status_t      status;
    logic [DEPTH-1:0]  sel;
    logic [SLOT_W-1:0] idx;

    logic              out_valid_reg;
    skis_status_t      out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    // Input unpack
    assign cmd_key = s_tdata[KEY_W-1:0];
    assign held    = s_tdata[KEY_W +: HELD_W];
    assign is_rem  = (s_tuser[0] == CMD_REMOVE);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Row of slot cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        skis_link_t       left_lnk;
        logic [KEY_W-1:0] right_key;

        if (g == 0) begin : g_first
            assign left_lnk = '{key: '0, gt: 1'b0, ge: 1'b0};
        end else begin : g_mid
            assign left_lnk = link_vec[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key = '0;
        end else begin : g_inner
            assign right_key = link_vec[g+1].key;
        end

        skis_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd_i       (cmd),
            .left_i      (left_lnk),
            .right_key_i (right_key),
            .link_o      (link_vec[g]),
            .ins_bnd_o   (ins_bnd[g]),
            .rem_bnd_o   (rem_bnd[g]),
            .eq_o        (eq_vec[g])
        );
    end

    // Decide the outcome
    always_comb begin
        key_zero = (cmd_key == '0);
        any_eq   = |eq_vec;
        found    = |(rem_bnd & eq_vec);
        room     = link_vec[DEPTH-1].gt;
        if (!is_rem) begin
            priority if (held >= HELD_W'(DEPTH)) status = ST_FULL;
            else if (key_zero || any_eq)         status = ST_DUP;
            else if (!room)                      status = ST_FULL;
            else                                 status = ST_DONE;
        end else begin
            status = (key_zero || !found) ? ST_NOT_FOUND : ST_DONE;
        end
    end

    // Slot index from the one-hot boundary, low bits only
    always_comb begin
        sel = is_rem ? rem_bnd : ins_bnd;
        idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (sel[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
    end

    assign cmd = '{key:    cmd_key,
                   ins_en: accept && !is_rem && (status == ST_DONE),
                   rem_en: accept &&  is_rem && (status == ST_DONE)};

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= status;
            out_slot_reg   <= (status == ST_DONE) ? idx : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W - SLOT_W){1'b0}}, out_slot_reg, out_status_reg};

    // Checks
    a_slot_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != ST_DONE) |-> (out_slot_reg == '0))
        else $error("slot nonzero with error status");

    a_ins_bnd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(ins_bnd))
        else $error("insert thermometer broken, list not sorted");

    a_rem_clears_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem_en |=> (link_vec[DEPTH-1].key == '0))
        else $error("last slot not cleared after remove");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_one_shift_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins_en && cmd.rem_en))
        else $error("insert and remove enabled together");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skis_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int BLOCKS     = 7;
    localparam int BLOCK_LEN  = 96;
    localparam int POOL_N     = 16;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct {
        skis_status_t      status;
        logic [SLOT_W-1:0] slot;
    } set_result_t;

    // Shadow copy of the slot row plus the queue of results still owed by the block
    class key_set_scoreboard;
        logic [KEY_W-1:0] slots[DEPTH];
        set_result_t      owed[$];
        int               errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            errors = 0;
        endfunction

        function int count();
            int n;
            n = 0;
            foreach (slots[i]) if (slots[i] != '0) n++;
            return n;
        endfunction

        function logic [KEY_W-1:0] key_at(int idx);
            return slots[idx];
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function set_result_t do_insert(logic [KEY_W-1:0] key, logic [HELD_W-1:0] held);
            set_result_t r;
            r.status = ST_FULL;
            r.slot   = '0;
            if (held >= DEPTH) return r;
            r.status = ST_DUP;
            if (key == '0) return r;
            foreach (slots[i]) if (slots[i] == key) return r;
            r.status = ST_FULL;
            for (int i = 0; i < DEPTH; i++) begin
                if (slots[i] == '0 || key < slots[i]) begin
                    // open a gap; the key in the last slot may fall off the end
                    for (int j = DEPTH - 1; j > i; j--) slots[j] = slots[j-1];
                    slots[i] = key;
                    r.status = ST_DONE;
                    r.slot   = i[SLOT_W-1:0];
                    return r;
                end
            end
            return r;
        endfunction

        function set_result_t do_remove(logic [KEY_W-1:0] key);
            set_result_t r;
            r.status = ST_NOT_FOUND;
            r.slot   = '0;
            if (key == '0) return r;
            for (int i = 0; i < DEPTH; i++) begin
                if (slots[i] == key) begin
                    for (int j = i; j + 1 < DEPTH; j++) slots[j] = slots[j+1];
                    slots[DEPTH-1] = '0;
                    r.status = ST_DONE;
                    r.slot   = i[SLOT_W-1:0];
                    return r;
                end
            end
            return r;
        endfunction

        // Accepted command word: update the shadow row and queue its result
        function void note_command(logic cmd, logic [KEY_W-1:0] key, logic [HELD_W-1:0] held);
            if (cmd == CMD_INSERT) owed.push_back(do_insert(key, held));
            else owed.push_back(do_remove(key));
        endfunction

        // Accepted result word: compare against the oldest owed result
        function void check_result(logic [M_TDATA_W-1:0] word, realtime t);
            set_result_t exp_r;
            logic [STATUS_W-1:0] got_status;
            logic [SLOT_W-1:0]   got_slot;
            got_status = word[STATUS_W-1:0];
            got_slot   = word[STATUS_W +: SLOT_W];
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word status=%0d slot=%0d",
                         t, got_status, got_slot);
                return;
            end
            exp_r = owed.pop_front();
            if (got_status !== exp_r.status) begin
                errors++;
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         t, exp_r.status, got_status);
            end
            if (got_slot !== exp_r.slot) begin
                errors++;
                $display("%0t: slot mismatch expected=%0d actual=%0d",
                         t, exp_r.slot, got_slot);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    key_set_scoreboard sb = new();

    logic [KEY_W-1:0] key_pool[POOL_N];
    int               cycle_cnt;
    int               idle_cycles;

    sorted_key_set_insert_remove_core #(.DEPTH(DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, $realtime);
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls, free-running stretches, and long hold-offs
    initial begin
        int hold_left;
        int free_left;
        int r;
        hold_left = 0;
        free_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left = hold_left - 1;
            end else if (cycle_cnt == 220 || $urandom_range(0, 599) == 0) begin
                // long hold-off so the output register fills and s_tready drops
                hold_left = $urandom_range(40, 80);
                m_tready  <= 1'b0;
            end else if (free_left > 0) begin
                m_tready  <= 1'b1;
                free_left = free_left - 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    free_left = $urandom_range(20, 60);
                    m_tready  <= 1'b1;
                end else if (r < 9) begin
                    hold_left = $urandom_range(2, 10);
                    m_tready  <= 1'b0;
                end else begin
                    m_tready <= (r >= 35);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'($urandom());
    endfunction

    // Offer one command word and hold it until accepted
    task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key,
                             input logic [HELD_W-1:0] held);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({held, key});
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, key, held);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Stop offering until every owed result has come back
    task automatic drain();
        idle_sender(1);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_N; i++) begin
            if (i < 6) key_pool[i] = KEY_W'($urandom_range(1, 40));
            else if (i == 6) key_pool[i] = KEY_MAX;
            else key_pool[i] = rand_key();
            if (key_pool[i] == '0) key_pool[i] = KEY_W'(1);
        end
    endtask

    // One random command, biased so the set fills and empties repeatedly
    task automatic send_random();
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [HELD_W-1:0] held;
        int               cnt;
        int               p_ins;
        int               r;
        cnt   = sb.count();
        p_ins = (cnt <= 2) ? 80 : (cnt >= DEPTH - 1) ? 35 : 55;
        cmd   = ($urandom_range(0, 99) < p_ins) ? CMD_INSERT : CMD_REMOVE;
        r = $urandom_range(0, 99);
        if (cmd == CMD_REMOVE && cnt > 0 && r < 50) key = sb.key_at($urandom_range(0, cnt - 1));
        else if (r < 86) key = key_pool[$urandom_range(0, POOL_N - 1)];
        else if (r < 98) key = rand_key();
        else key = '0;
        r = $urandom_range(0, 99);
        if (r < 80) held = HELD_W'(cnt);
        else if (r < 88) held = HELD_W'($urandom_range(0, cnt));
        else if (r < 95) held = HELD_W'($urandom_range(DEPTH, 255));
        else held = HELD_W'($urandom_range(0, 255));
        send_word(cmd, key, held);
    endtask

    // Stimulus
    initial begin
        logic no_gaps;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cycle_cnt = 0;
        idle_cycles = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty set, zero keys, full by count, fill, stale count, removes
        send_word(CMD_REMOVE, 31'd5, 8'd0);
        send_word(CMD_INSERT, 31'd0, 8'd0);
        send_word(CMD_REMOVE, 31'd0, 8'd0);
        send_word(CMD_INSERT, 31'd10, 8'd8);
        send_word(CMD_INSERT, 31'd10, 8'd255);
        send_word(CMD_INSERT, KEY_MAX, HELD_W'(sb.count()));
        send_word(CMD_INSERT, 31'd1, HELD_W'(sb.count()));
        send_word(CMD_INSERT, 31'd1, HELD_W'(sb.count()));
        send_word(CMD_INSERT, 31'd0, HELD_W'(sb.count()));
        for (int i = 1; i <= 6; i++)
            send_word(CMD_INSERT, KEY_W'(i * 1000), HELD_W'(sb.count()));
        send_word(CMD_INSERT, 31'd500, HELD_W'(sb.count()));
        // stale count on a full row: the largest key is pushed out
        send_word(CMD_INSERT, KEY_MAX - 1, 8'd7);
        // stale count, nothing larger held: refused as full
        send_word(CMD_INSERT, KEY_MAX, 8'd0);
        send_word(CMD_REMOVE, 31'd1, 8'd0);
        send_word(CMD_REMOVE, KEY_MAX - 1, 8'd0);
        send_word(CMD_REMOVE, 31'd3000, 8'd0);
        send_word(CMD_REMOVE, 31'h2AAA_AAAA, 8'd0);
        send_word(CMD_INSERT, 31'h5555_5555, HELD_W'(sb.count()));
        drain();

        // random blocks; the first runs gap-free so the forced hold-off backs up the input
        for (int b = 0; b < BLOCKS; b++) begin
            refill_pool();
            no_gaps = (b == 0) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BLOCK_LEN; n++) begin
                send_random();
                if (!no_gaps) idle_sender(pick_gap());
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
